@@ sv/rsa_pkg.sv @@
// Shared types and constants for the resource slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsa_pkg;

    // Default pool size and the per-request result limit
    localparam int POOL_SIZE_DEF = 8;
    localparam int MAX_RESULTS   = 8;

    // Result status codes
    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // Request type codes
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // latch the request on an input transfer
        logic eval;   // decide the request, emit single-result answers
        logic step;   // grant one slot
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic go_grant;   // allocate request will be granted
        logic last_step;  // current grant step is the final one
    } dp_stat_t;

endpackage

@@ sv/rsa_ctrl.sv @@
// Controller state machine of the resource slot allocator.
// Depends on rsa_pkg (command and status structs).
`timescale 1ns / 1ps

module rsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output rsa_pkg::ctrl_cmd_t cmd,
    input  rsa_pkg::dp_stat_t  stat
);
    import rsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_GRANT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.go_grant ? S_GRANT : S_IDLE;
            end
            S_GRANT:
            begin
                cmd.step = 1'b1;
                if (stat.last_step)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ sv/rsa_datapath.sv @@
// Datapath of the resource slot allocator: in-use map, free counter,
// request latch, lowest-free search and result registers. Depends on rsa_pkg.
`timescale 1ns / 1ps

module rsa_datapath #(
    parameter int POOL_SIZE = rsa_pkg::POOL_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rsa_pkg::ctrl_cmd_t cmd,
    output rsa_pkg::dp_stat_t  stat,
    input  logic               req_type,
    input  logic [3:0]         count,
    input  logic signed [7:0]  slot,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic [2:0]         slot_index,
    output logic               index_valid,
    output logic [3:0]         granted_count,
    output logic [3:0]         free_count,
    output logic               last
);
    import rsa_pkg::*;

    localparam int SW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int FCW = ($clog2(POOL_SIZE + 1) > 4) ? $clog2(POOL_SIZE + 1) : 4;
    localparam int IW  = (SW > 3) ? SW : 3;
    localparam logic [7:0]     POOL_LIM = 8'(POOL_SIZE);
    localparam logic [FCW-1:0] FREE_RST = FCW'(POOL_SIZE);
    localparam logic [3:0]     CNT_LIM  = 4'(MAX_RESULTS);

    // State and request latch
    logic [POOL_SIZE-1:0] map_reg, map_next;
    logic [FCW-1:0]       free_reg, free_next;
    logic [3:0]           remain_reg, remain_next;
    logic                 req_type_reg;
    logic [3:0]           count_reg;
    logic [7:0]           slot_reg;

    // Result staging
    logic                 res_we;
    logic [1:0]           res_status;
    logic [2:0]           res_index;
    logic                 res_ivalid;
    logic [3:0]           res_granted;
    logic [3:0]           res_free;
    logic                 res_last;

    logic [SW-1:0]        pick;
    logic [IW-1:0]        pick_ext;
    logic                 in_range;
    logic                 was_used;
    logic                 go_grant;

    // Lowest free slot
    always_comb
    begin
        pick = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!map_reg[i])
            begin
                pick = SW'(i);
            end
        end
    end

    assign pick_ext = IW'(pick);
    assign in_range = !slot_reg[7] && (slot_reg < POOL_LIM);
    assign was_used = map_reg[slot_reg[SW-1:0]];
    assign go_grant = (req_type_reg == REQ_ALLOC) && (count_reg != 4'd0)
                      && (count_reg <= CNT_LIM) && (free_reg >= FCW'(count_reg));

    assign stat.go_grant  = go_grant;
    assign stat.last_step = (remain_reg == 4'd1);

    // Request evaluation and grant steps
    always_comb
    begin
        map_next    = map_reg;
        free_next   = free_reg;
        remain_next = remain_reg;
        res_we      = 1'b0;
        res_status  = ST_GRANTED;
        res_index   = 3'd0;
        res_ivalid  = 1'b0;
        res_granted = 4'd0;
        res_free    = free_reg[3:0];
        res_last    = 1'b1;
        if (cmd.eval)
        begin
            if (req_type_reg == REQ_FREE)
            begin
                res_we = 1'b1;
                if (in_range)
                begin
                    map_next[slot_reg[SW-1:0]] = 1'b0;
                    free_next  = free_reg + FCW'(was_used);
                    res_status = ST_FREED;
                end
                else
                begin
                    res_status = ST_IGNORED;
                end
                res_free = free_next[3:0];
            end
            else if (go_grant)
            begin
                free_next   = free_reg - FCW'(count_reg);
                remain_next = count_reg;
            end
            else
            begin
                res_we     = 1'b1;
                res_status = (count_reg == 4'd0) ? ST_GRANTED : ST_NOFREE;
            end
        end
        else if (cmd.step)
        begin
            // free_reg already holds the count after the whole grant
            map_next[pick] = 1'b1;
            remain_next    = remain_reg - 4'd1;
            res_we         = 1'b1;
            res_index      = pick_ext[2:0];
            res_ivalid     = 1'b1;
            res_granted    = count_reg;
            res_last       = (remain_reg == 4'd1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg      <= '0;
            free_reg     <= FREE_RST;
            result_valid <= 1'b0;
        end
        else
        begin
            map_reg      <= map_next;
            free_reg     <= free_next;
            result_valid <= res_we;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            count_reg    <= count;
            slot_reg     <= slot;
        end
        if (res_we)
        begin
            status        <= res_status;
            slot_index    <= res_index;
            index_valid   <= res_ivalid;
            granted_count <= res_granted;
            free_count    <= res_free;
            last          <= res_last;
        end
    end

endmodule

@@ sv/resource_slot_allocator.sv @@
// Resource slot allocator: accept on start && !busy; results strobe on result_valid.
// A free, an empty allocate or a refused allocate is latched on acceptance and decided
// in S_EVAL, which registers its single result; busy falls with the return to S_IDLE,
// and only then is the next request taken. A grant of N slots passes through S_EVAL,
// then emits N back-to-back results, one per cycle from the lowest-free search; no new
// request is taken until the last of them. The receiver cannot stall.
// Reset clears the in-use map (all slots free) and sets the free count to the pool size.
`timescale 1ns / 1ps

module resource_slot_allocator #(
    parameter int POOL_SIZE = rsa_pkg::POOL_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              req_type,
    input  logic [3:0]        count,
    input  logic signed [7:0] slot,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic [2:0]        slot_index,
    output logic              index_valid,
    output logic [3:0]        granted_count,
    output logic [3:0]        free_count,
    output logic              last
);
    import rsa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer
    rsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Map, counters and result registers
    rsa_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .count         (count),
        .slot          (slot),
        .result_valid  (result_valid),
        .status        (status),
        .slot_index    (slot_index),
        .index_valid   (index_valid),
        .granted_count (granted_count),
        .free_count    (free_count),
        .last          (last)
    );

endmodule

@@ sv/rsa_checker.sv @@
// Port-level checks for the resource slot allocator, bound to the top level.
// Depends on rsa_pkg (status codes).
`timescale 1ns / 1ps

module rsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [1:0] status,
    input logic       index_valid,
    input logic [3:0] granted_count,
    input logic       last
);
    import rsa_pkg::*;

    // A transfer makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // A granted slot only comes with a granted status
    a_index_granted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && index_valid |-> status == ST_GRANTED && granted_count != 4'd0)
        else $error("slot index on a non-grant result");

    // Non-grant answers are single, empty results
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_GRANTED |-> last && !index_valid && granted_count == 4'd0)
        else $error("non-grant result is not a single empty result");

    // A grant burst runs without gaps until its last result
    a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && index_valid)
        else $error("gap inside a grant burst");

    // Results before the last one of a grant burst arrive while the block is still busy
    a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("block idle in the middle of a grant burst");

endmodule

bind resource_slot_allocator rsa_checker u_rsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .status        (status),
    .index_valid   (index_valid),
    .granted_count (granted_count),
    .last          (last)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for resource_slot_allocator: directed and random requests,
// each checked against an in-bench prediction of the in-use map and result stream.
// Depends on rsa_pkg and resource_slot_allocator.
`timescale 1ns / 1ps

module tb_top;
    import rsa_pkg::*;

    localparam int POOL       = POOL_SIZE_DEF;
    localparam int N_RANDOM   = 470;
    localparam int IDLE_PCT   = 37;
    localparam int CYCLE_CAP  = 200000;
    localparam int TAIL_WAIT  = 20;

    // One request as driven on the input ports
    typedef struct {
        req_t              req;
        logic [3:0]        cnt;
        logic signed [7:0] slot;
    } request_t;

    // One result as expected on the output ports
    typedef struct {
        status_t    status;
        logic [2:0] index;
        logic       valid;
        logic [3:0] granted;
        logic [3:0] free_left;
        logic       last;
    } grant_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              req_type = 1'b0;
    logic [3:0]        count = 4'd0;
    logic signed [7:0] slot = 8'sd0;
    logic              result_valid;
    logic [1:0]        status;
    logic [2:0]        slot_index;
    logic              index_valid;
    logic [3:0]        granted_count;
    logic [3:0]        free_count;
    logic              last;

    request_t      request_fifo[$];
    grant_result_t expected_results[$];
    logic [POOL-1:0] slots_in_use = '0;
    int            n_requests = 0;
    int            n_taken = 0;
    int            n_errors = 0;
    int            n_cycles = 0;

    resource_slot_allocator #(
        .POOL_SIZE(POOL)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .count(count),
        .slot(slot),
        .result_valid(result_valid),
        .status(status),
        .slot_index(slot_index),
        .index_valid(index_valid),
        .granted_count(granted_count),
        .free_count(free_count),
        .last(last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_CAP)
        begin
            $display("resource_slot_allocator regression: fail");
            $finish;
        end
    end

    function automatic grant_result_t mk_result(status_t st, logic [2:0] idx, logic v,
                                                logic [3:0] g, logic l);
        grant_result_t r;
        r.status    = st;
        r.index     = idx;
        r.valid     = v;
        r.granted   = g;
        r.free_left = 4'($countones(~slots_in_use));
        r.last      = l;
        return r;
    endfunction

    // Update the in-use map for one request and queue the results it produces
    task automatic predict_allocation(input req_t rq, input logic [3:0] cnt,
                                      input logic signed [7:0] idx);
        logic [2:0] picked[$];
        if (rq == REQ_FREE)
        begin
            if (idx >= 0 && idx < POOL)
            begin
                slots_in_use[idx] = 1'b0;
                expected_results.push_back(mk_result(ST_FREED, 3'd0, 1'b0, 4'd0, 1'b1));
            end
            else
                expected_results.push_back(mk_result(ST_IGNORED, 3'd0, 1'b0, 4'd0, 1'b1));
        end
        else if (cnt == 4'd0)
            expected_results.push_back(mk_result(ST_GRANTED, 3'd0, 1'b0, 4'd0, 1'b1));
        else if (cnt > MAX_RESULTS || $countones(~slots_in_use) < cnt)
            expected_results.push_back(mk_result(ST_NOFREE, 3'd0, 1'b0, 4'd0, 1'b1));
        else
        begin
            // lowest free slots first, all marked before any result is reported
            for (int i = 0; i < POOL && picked.size() < cnt; i++)
                if (!slots_in_use[i])
                    picked.push_back(3'(i));
            foreach (picked[k])
                slots_in_use[picked[k]] = 1'b1;
            foreach (picked[k])
                expected_results.push_back(mk_result(ST_GRANTED, picked[k], 1'b1, cnt,
                                                     k == picked.size() - 1));
        end
    endtask

    // Driver: one transfer per start && !busy edge, random idle gaps between items
    always @(posedge clk)
    begin : drive_proc
        request_t rq;
        logic     taken;
        logic     idle_now;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_allocation(req_t'(req_type), count, slot);
                n_taken = n_taken + 1;
            end
            if (!start || taken)
            begin
                // no idle gaps in the middle of the random part
                idle_now = !(n_taken >= 200 && n_taken < 300)
                           && ($urandom_range(99) < IDLE_PCT);
                if (request_fifo.size() > 0 && !idle_now)
                begin
                    rq = request_fifo.pop_front();
                    start    <= 1'b1;
                    req_type <= rq.req;
                    count    <= rq.cnt;
                    slot     <= rq.slot;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation
    always @(posedge clk)
    begin : check_proc
        grant_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                n_errors = n_errors + 1;
                if (n_errors <= 10)
                    $display("unexpected result: status %0d index %0d last %0d",
                             status, slot_index, last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || slot_index !== want.index
                    || index_valid !== want.valid || granted_count !== want.granted
                    || free_count !== want.free_left || last !== want.last)
                begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                        $display({"mismatch: exp st %0d idx %0d v %0d g %0d free %0d last %0d",
                                  " / got st %0d idx %0d v %0d g %0d free %0d last %0d"},
                                 want.status, want.index, want.valid, want.granted,
                                 want.free_left, want.last, status, slot_index, index_valid,
                                 granted_count, free_count, last);
                end
            end
        end
    end

    function automatic request_t mk_request(req_t rq, logic [3:0] cnt, logic [7:0] idx);
        request_t r;
        r.req  = rq;
        r.cnt  = cnt;
        r.slot = idx;
        return r;
    endfunction

    // Stimulus and end of run
    initial
    begin : stim_proc
        int r;
        int sel;
        // directed part: empty pool, full pool, bounds and oversized counts
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd0, 8'h00));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd8, 8'h00));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd1, 8'h00));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd0, 8'h00));
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'd3));
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'd3));   // already free
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'h7F));
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'hFF));  // -1
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'h80));  // most negative
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'(POOL)));
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'(POOL - 1)));
        request_fifo.push_back(mk_request(REQ_FREE, 4'd0, 8'd0));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd4, 8'h00)); // refused, 3 free
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd3, 8'h00));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd9, 8'h00));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd15, 8'hFF));
        for (int i = 0; i < POOL; i++)
            request_fifo.push_back(mk_request(REQ_FREE, 4'hF, 8'(i)));
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd12, 8'h00)); // oversized, pool empty
        request_fifo.push_back(mk_request(REQ_ALLOC, 4'd5, 8'h00));

        // random part: mostly in-range allocates and frees, some out-of-range noise
        for (int n = 0; n < N_RANDOM; n++)
        begin
            r   = $urandom_range(99);
            sel = $urandom_range(99);
            if (r < 45)
            begin
                if (sel < 8)
                    request_fifo.push_back(mk_request(REQ_ALLOC, 4'd0, 8'($urandom)));
                else if (sel < 78)
                    request_fifo.push_back(mk_request(REQ_ALLOC, 4'($urandom_range(4, 1)),
                                                      8'($urandom)));
                else if (sel < 93)
                    request_fifo.push_back(mk_request(REQ_ALLOC, 4'($urandom_range(8, 5)),
                                                      8'($urandom)));
                else
                    request_fifo.push_back(mk_request(REQ_ALLOC, 4'($urandom_range(15, 9)),
                                                      8'($urandom)));
            end
            else if (sel < 85)
                request_fifo.push_back(mk_request(REQ_FREE, 4'($urandom),
                                                  8'($urandom_range(POOL - 1, 0))));
            else
                request_fifo.push_back(mk_request(REQ_FREE, 4'($urandom), 8'($urandom)));
        end
        n_requests = request_fifo.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // all requests transferred and every result seen
        while (n_taken != n_requests || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (n_errors == 0)
            $display("resource_slot_allocator regression: pass");
        else
            $display("resource_slot_allocator regression: fail");
        $finish;
    end

endmodule
